### design/rse_pkg.sv
// Package: shared constants, payload types, cell control and GF(256) helpers.
`timescale 1ns / 1ps
`default_nettype none
package rse_pkg;

   localparam int MAX_PARITY_DEF      = 32;
   localparam int CODEWORD_LENGTH_DEF = 255;
   localparam int RESET_PARITY        = 32;
   localparam int SYM_W               = 8;
   localparam int CFG_W               = 6;
   localparam logic [SYM_W:0] FIELD_POLY = 9'h11D;

   typedef struct packed {
      logic [SYM_W-1:0] message_byte;
   } req_payload_type;

   typedef struct packed {
      logic [SYM_W-1:0] out_byte;
      logic             is_parity;
      logic             end_of_codeword;
   } rsp_payload_type;

   // Per-cycle command for the row of cells.
   typedef struct packed {
      logic clear;    // drop generator and remainder
      logic build;    // multiply generator by (x + root)
      logic encode;   // absorb one message beat
      logic shift;    // move remainder one cell toward the top
   } cell_ctl_type;

   // Multiply by alpha (x) modulo the field polynomial.
   function automatic logic [SYM_W-1:0] gf_xtime(input logic [SYM_W-1:0] a);
      logic [SYM_W:0] t;
      t = {a, 1'b0};
      if (t[SYM_W]) begin
         t = t ^ FIELD_POLY;
      end
      return t[SYM_W-1:0];
   endfunction

   // Shift-and-add GF(256) multiply.
   function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                              input logic [SYM_W-1:0] b);
      logic [SYM_W-1:0] x;
      logic [SYM_W-1:0] acc;
      x   = a;
      acc = '0;
      for (int i = 0; i < SYM_W; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         x = gf_xtime(x);
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

### design/rse_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
`default_nettype none
interface rse_stream_if #(
   parameter type payload_type = rse_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/rse_cell.sv
// One cell of the encoder row: a generator coefficient and a remainder byte.
`timescale 1ns / 1ps
`default_nettype none
module rse_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rse_pkg::cell_ctl_type     ctl,
   input  wire logic [rse_pkg::SYM_W-1:0] root,
   input  wire logic [rse_pkg::SYM_W-1:0] feedback,
   input  wire logic [rse_pkg::SYM_W-1:0] coeff_up,
   input  wire logic [rse_pkg::SYM_W-1:0] parity_down,
   output logic      [rse_pkg::SYM_W-1:0] coeff,
   output logic      [rse_pkg::SYM_W-1:0] parity
);

   logic [rse_pkg::SYM_W-1:0] coeff_ff, coeff_in;
   logic [rse_pkg::SYM_W-1:0] parity_ff, parity_in;

   always_comb begin
      coeff_in  = coeff_ff;
      parity_in = parity_ff;
      if (ctl.clear) begin
         coeff_in  = '0;
         parity_in = '0;
      end else begin
         if (ctl.build) begin
            coeff_in = coeff_ff ^ rse_pkg::gf_mul(root, coeff_up);
         end
         if (ctl.encode) begin
            parity_in = parity_down ^ rse_pkg::gf_mul(feedback, coeff_ff);
         end else if (ctl.shift) begin
            parity_in = parity_down;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff  <= '0;
         parity_ff <= '0;
      end else begin
         coeff_ff  <= coeff_in;
         parity_ff <= parity_in;
      end
   end

   assign coeff  = coeff_ff;
   assign parity = parity_ff;

endmodule
`default_nettype wire

### design/reed_solomon_systematic_encoder.sv
// Top level: systematic RS(255) encoder over GF(256) built from a row of LFSR cells.
//
// Usage:
//  - req_if carries one message byte per beat; rsp_if returns the codeword, one
//    symbol per beat: each message byte echoed, then the parity bytes, highest
//    coefficient first, with end_of_codeword on the last one.
//  - csr_we/csr_wdata set the parity count p (saturated to 1..MAX_PARITY and to
//    at most CODEWORD_LENGTH-1). A write drops any codeword in progress and
//    rebuilds the generator; req_if.ready stays low meanwhile.
//  - Reset clears the remainder and the byte count and rebuilds the generator
//    for a count of 32 before the first beat is taken.
//  - Each request beat is echoed on rsp_if from the output register in the cycle
//    after it is taken. Message bytes flow at one per cycle while rsp_if is
//    ready; after byte CODEWORD_LENGTH-p the p parity beats leave at one per
//    cycle, also while rsp_if is ready, and req_if is held off. The rate is set by
//    the single output register, which is the only path out of the cell row.
//  - A stall on rsp_if holds the output register and the cell row; the next
//    request beat is taken in the same cycle that the waiting beat leaves.
`timescale 1ns / 1ps
`default_nettype none
module reed_solomon_systematic_encoder #(
   parameter int MAX_PARITY      = rse_pkg::MAX_PARITY_DEF,
   parameter int CODEWORD_LENGTH = rse_pkg::CODEWORD_LENGTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   rse_stream_if.sink                     req_if,
   rse_stream_if.source                   rsp_if,
   input  wire logic                      csr_we,
   input  wire logic [rse_pkg::CFG_W-1:0] csr_wdata
);

   localparam int SW = rse_pkg::SYM_W;
   localparam int PW = $clog2(MAX_PARITY + 1);
   localparam logic [7:0] MAXP8 = 8'(MAX_PARITY);
   localparam logic [7:0] CLM1  = 8'(CODEWORD_LENGTH - 1);
   localparam logic [7:0] CL8   = 8'(CODEWORD_LENGTH);
   // Reset parity count, saturated like a register write.
   localparam int RST_A = (rse_pkg::RESET_PARITY < 1) ? 1 : rse_pkg::RESET_PARITY;
   localparam int RST_B = (RST_A > MAX_PARITY) ? MAX_PARITY : RST_A;
   localparam int RST_C = (RST_B > CODEWORD_LENGTH - 1) ? CODEWORD_LENGTH - 1 : RST_B;
   localparam logic [PW-1:0] RST_P = PW'(RST_C);
   localparam logic [PW-1:0] ONE_P = PW'(1);

   typedef enum logic [2:0] {
      ST_BUILD  = 3'b001,
      ST_MSG    = 3'b010,
      ST_PARITY = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [PW-1:0]            step_ff, step_in;     // build steps or parity beats left
   logic [PW-1:0]            pcount_ff, pcount_in; // active parity count
   logic [7:0]               bcount_ff, bcount_in; // message bytes taken
   logic [SW-1:0]            root_ff, root_in;     // alpha^i during the build
   logic                     rsp_valid_ff, rsp_valid_in;
   rse_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic                  advance, req_fire, par_fire, last_msg;
   logic [7:0]            msg_len, cfg_ext, cfg_sat;
   logic [PW-1:0]         cfg_p;
   logic [SW-1:0]         feedback;
   rse_pkg::cell_ctl_type cell_ctl;
   logic [SW-1:0]         coeff_w  [MAX_PARITY];
   logic [SW-1:0]         parity_w [MAX_PARITY];
   logic [MAX_PARITY-1:0] parity_nz;

   // Saturate the written count.
   always_comb begin
      cfg_ext = 8'(csr_wdata);
      cfg_sat = cfg_ext;
      if (cfg_sat < 8'd1) begin
         cfg_sat = 8'd1;
      end
      if (cfg_sat > MAXP8) begin
         cfg_sat = MAXP8;
      end
      if (cfg_sat > CLM1) begin
         cfg_sat = CLM1;
      end
      cfg_p = cfg_sat[PW-1:0];
   end

   // The output register frees up when empty or when its beat leaves.
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_MSG) && advance;
   assign req_fire     = req_if.valid && req_if.ready;
   assign par_fire     = (state_ff == ST_PARITY) && advance;
   assign msg_len      = CL8 - 8'(pcount_ff);
   assign last_msg     = (8'(bcount_ff + 8'd1) == msg_len);

   // The generator sits top-aligned, so the remainder's top is always the last cell.
   assign feedback = req_if.payload.message_byte ^ parity_w[MAX_PARITY-1];

   always_comb begin
      cell_ctl.clear  = csr_we;
      cell_ctl.build  = (state_ff == ST_BUILD);
      cell_ctl.encode = req_fire;
      cell_ctl.shift  = par_fire;
   end

   for (genvar k = 0; k < MAX_PARITY; k++) begin : g_cell
      logic [SW-1:0] coeff_up, parity_down;
      if (k == MAX_PARITY - 1) begin : g_top
         assign coeff_up = SW'(1); // monic leading term
      end else begin : g_mid
         assign coeff_up = coeff_w[k+1];
      end
      if (k == 0) begin : g_bot
         assign parity_down = '0;
      end else begin : g_up
         assign parity_down = parity_w[k-1];
      end
      rse_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .root        (root_ff),
         .feedback    (feedback),
         .coeff_up    (coeff_up),
         .parity_down (parity_down),
         .coeff       (coeff_w[k]),
         .parity      (parity_w[k])
      );
      assign parity_nz[k] = |parity_w[k];
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pcount_in    = pcount_ff;
      bcount_in    = bcount_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // Drop the waiting beat once taken; a new load below overrides.
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         state_in  = ST_BUILD;
         step_in   = cfg_p;
         pcount_in = cfg_p;
         bcount_in = '0;
         root_in   = SW'(1);
      end else begin
         unique case (state_ff)
            ST_BUILD: begin
               root_in = rse_pkg::gf_xtime(root_ff);
               step_in = step_ff - ONE_P;
               if (step_ff == ONE_P) begin
                  state_in = ST_MSG;
               end
            end
            ST_MSG: begin
               if (req_fire) begin
                  rsp_valid_in           = 1'b1;
                  rsp_in.out_byte        = req_if.payload.message_byte;
                  rsp_in.is_parity       = 1'b0;
                  rsp_in.end_of_codeword = 1'b0;
                  bcount_in              = bcount_ff + 8'd1;
                  if (last_msg) begin
                     state_in  = ST_PARITY;
                     step_in   = pcount_ff;
                     bcount_in = '0;
                  end
               end
            end
            ST_PARITY: begin
               if (par_fire) begin
                  rsp_valid_in           = 1'b1;
                  rsp_in.out_byte        = parity_w[MAX_PARITY-1];
                  rsp_in.is_parity       = 1'b1;
                  rsp_in.end_of_codeword = (step_ff == ONE_P);
                  step_in                = step_ff - ONE_P;
                  if (step_ff == ONE_P) begin
                     state_in = ST_MSG;
                  end
               end
            end
            default: begin
               state_in = ST_BUILD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BUILD;
         step_ff      <= RST_P;
         pcount_ff    <= RST_P;
         bcount_ff    <= '0;
         root_ff      <= SW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pcount_ff    <= pcount_in;
         bcount_ff    <= bcount_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // The last parity beat leaves the whole remainder clear.
   a_clear_after_codeword: assert property (@(posedge clock) disable iff (reset)
      par_fire && (step_ff == ONE_P) && !csr_we |=> (parity_nz == '0))
      else $error("remainder not clear after final parity beat");

   a_count_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MSG) |-> (bcount_ff < msg_len))
      else $error("message byte count reached codeword message length");

   a_parity_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PARITY) |-> (step_ff != '0) && (step_ff <= pcount_ff))
      else $error("parity beat counter out of range");

   a_end_is_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.end_of_codeword |-> rsp_ff.is_parity)
      else $error("end of codeword marked on a message beat");

endmodule
`default_nettype wire

### tb/sv/reed_solomon_codeword_checker.sv
// Checker: predicts the RS(255) codeword stream and compares every output beat.
`timescale 1ns / 1ps
module reed_solomon_codeword_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic [rse_pkg::SYM_W-1:0] req_byte,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  rse_pkg::rsp_payload_type       rsp_beat,
   input  wire logic                      csr_we,
   input  wire logic [rse_pkg::CFG_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             pending_beats
);
   import rse_pkg::*;

   localparam int MAX_P        = MAX_PARITY_DEF;
   localparam int CW_LEN       = CODEWORD_LENGTH_DEF;
   localparam int REPORT_LIMIT = 10;

   // Antilog / log tables of GF(256) for alpha = 2.
   logic [SYM_W-1:0] alpha_pow [0:254];
   int               alpha_log [0:255];

   int               parity_count;
   logic [SYM_W-1:0] gen_poly  [0:MAX_P];
   logic [SYM_W-1:0] remainder [0:MAX_P-1];
   int               message_count;
   rsp_payload_type  codeword_q [$];
   int               err_total;

   initial begin
      logic [SYM_W:0] v;
      v = 9'd1;
      for (int i = 0; i < 255; i++) begin
         alpha_pow[i]        = v[SYM_W-1:0];
         alpha_log[v[7:0]]   = i;
         v = {v[SYM_W-1:0], 1'b0};
         if (v[SYM_W]) v = v ^ FIELD_POLY;
      end
      err_total     = 0;
      mismatches    = 0;
      pending_beats = 0;
   end

   function automatic logic [SYM_W-1:0] gf_product(input logic [SYM_W-1:0] a,
                                                   input logic [SYM_W-1:0] b);
      if (a == '0 || b == '0) return '0;
      return alpha_pow[(alpha_log[a] + alpha_log[b]) % 255];
   endfunction

   function automatic int saturate_count(input logic [CFG_W-1:0] v);
      int c;
      c = int'(v);
      if (c < 1) c = 1;
      if (c > MAX_P) c = MAX_P;
      if (c > CW_LEN - 1) c = CW_LEN - 1;
      return c;
   endfunction

   // g(x) = (x + 1)(x + alpha)...(x + alpha^(p-1))
   function automatic void rebuild_generator();
      logic [SYM_W-1:0] root;
      root = 8'd1;
      for (int k = 0; k <= MAX_P; k++) gen_poly[k] = '0;
      gen_poly[0] = 8'd1;
      for (int i = 0; i < parity_count; i++) begin
         for (int j = i + 1; j > 0; j--)
            gen_poly[j] = gen_poly[j-1] ^ gf_product(gen_poly[j], root);
         gen_poly[0] = gf_product(gen_poly[0], root);
         root = gf_product(root, 8'd2);
      end
   endfunction

   function automatic void restart_codeword();
      for (int k = 0; k < MAX_P; k++) remainder[k] = '0;
      message_count = 0;
   endfunction

   // Echo the byte, advance the LFSR, and queue the parity run at codeword end.
   function automatic void absorb_message_byte(input logic [SYM_W-1:0] b);
      logic [SYM_W-1:0] fb;
      rsp_payload_type  sym;
      fb = b ^ remainder[parity_count-1];
      for (int j = parity_count - 1; j > 0; j--)
         remainder[j] = remainder[j-1] ^ gf_product(fb, gen_poly[j]);
      remainder[0] = gf_product(fb, gen_poly[0]);
      sym.out_byte        = b;
      sym.is_parity       = 1'b0;
      sym.end_of_codeword = 1'b0;
      codeword_q.push_back(sym);
      message_count = (message_count + 1) % 256;
      if (message_count >= CW_LEN - parity_count) begin
         for (int j = 0; j < parity_count; j++) begin
            sym.out_byte        = remainder[parity_count-1-j];
            sym.is_parity       = 1'b1;
            sym.end_of_codeword = (j == parity_count - 1);
            codeword_q.push_back(sym);
         end
         restart_codeword();
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         parity_count = saturate_count(CFG_W'(RESET_PARITY));
         rebuild_generator();
         restart_codeword();
         codeword_q.delete();
      end else begin
         if (csr_we) begin
            parity_count = saturate_count(csr_wdata);
            rebuild_generator();
            restart_codeword();
         end
         // Check the leaving beat before queuing anything from this edge.
         if (rsp_valid && rsp_ready) begin
            if (codeword_q.size() == 0) begin
               err_total++;
               if (err_total <= REPORT_LIMIT)
                  $display("unexpected beat: byte=%02h parity=%0b end=%0b",
                           rsp_beat.out_byte, rsp_beat.is_parity,
                           rsp_beat.end_of_codeword);
            end else begin
               want = codeword_q.pop_front();
               if (rsp_beat.out_byte !== want.out_byte ||
                   rsp_beat.is_parity !== want.is_parity ||
                   rsp_beat.end_of_codeword !== want.end_of_codeword) begin
                  err_total++;
                  if (err_total <= REPORT_LIMIT)
                     $display({"mismatch: expected byte=%02h parity=%0b end=%0b,",
                               " got byte=%02h parity=%0b end=%0b"},
                              want.out_byte, want.is_parity, want.end_of_codeword,
                              rsp_beat.out_byte, rsp_beat.is_parity,
                              rsp_beat.end_of_codeword);
               end
            end
         end
         if (req_valid && req_ready) absorb_message_byte(req_byte);
      end
      mismatches    <= err_total;
      pending_beats <= codeword_q.size();
   end

endmodule

### tb/sv/reed_solomon_systematic_encoder_tb.sv
// Testbench top: clock, reset, message stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module reed_solomon_systematic_encoder_tb;
   import rse_pkg::*;

   // Generous ceiling: a few hundred message beats plus their parity, with
   // gaps and stalls between them, plus the generator rebuilds.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MIN_BYTES    = 310;
   localparam int MIN_PHASES   = 6;
   localparam int TAIL_MAX     = 30;
   localparam int SETTLE       = 4;
   localparam int DRAIN_CYCLES = 40;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN,
      STALL_LONG
   } stall_mode_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;

   stall_mode_type   stall_mode;
   logic [7:0]       ready_pattern;
   logic [2:0]       stall_left;

   int               cycle_count = 0;
   int               mismatches;
   int               pending_beats;
   int               burst_left;
   int               gap_max;
   int               byte_total;

   rse_stream_if #(.payload_type(req_payload_type)) req_chan ();
   rse_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   reed_solomon_systematic_encoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Watch both channels and the register port; predict and compare.
   reed_solomon_codeword_checker codeword_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_byte      (req_chan.payload.message_byte),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_beat      (rsp_chan.payload),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending_beats (pending_beats)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abort on a hang: no handshake may stall the run past the ceiling.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver back-pressure. Each mode gives a different rhythm so that
   // stalls land on echo beats, on parity beats and on the last beat.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         ready_pattern  <= 8'b1011_0110;
         stall_left     <= '0;
      end else begin
         case (stall_mode)
            STALL_NONE: begin
               rsp_chan.ready <= 1'b1;
            end
            STALL_RANDOM: begin
               rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            end
            STALL_PATTERN: begin
               // rotate a fixed mask: periodic, phase-shifting stalls
               rsp_chan.ready <= ready_pattern[0];
               ready_pattern  <= {ready_pattern[0], ready_pattern[7:1]};
            end
            default: begin
               // rare but long stalls
               if (stall_left != 0) begin
                  rsp_chan.ready <= 1'b0;
                  stall_left     <= stall_left - 3'd1;
               end else if ($urandom_range(0, 15) == 0) begin
                  rsp_chan.ready <= 1'b0;
                  stall_left     <= 3'($urandom_range(1, 7));
               end else begin
                  rsp_chan.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Mostly random bytes, with the field extremes mixed in.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 15))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one message beat and hold it until the encoder takes it. Valid
   // stays high inside a burst; between bursts drop it for a random gap.
   task automatic send_message_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 80);
      end
      req_chan.valid                <= 1'b1;
      req_chan.payload.message_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      burst_left--;
      byte_total++;
   endtask

   // Wait until every predicted beat has left, then let the design settle.
   task automatic wait_drained(input int settle);
      do @(posedge clock); while (pending_beats != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_parity_count(input logic [CFG_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [7:0]       corner_bytes [0:7];
      logic [CFG_W-1:0] setting;
      int               fill;

      corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};

      // Drive every input to a known level before the first edge.
      reset                    = 1'b1;
      csr_we                   = 1'b0;
      csr_wdata                = '0;
      req_chan.valid           = 1'b0;
      req_chan.payload         = '0;
      rsp_chan.ready           = 1'b0;
      stall_mode               = STALL_NONE;
      burst_left               = 0;
      gap_max                  = 3;
      byte_total               = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Open the first codeword with the extreme byte values, under the
      // count of 32 that reset leaves; ready stays low while the reset
      // generator is built, so the first beat simply waits.
      foreach (corner_bytes[i]) send_message_byte(corner_bytes[i]);

      for (int phase = 0; phase < MIN_PHASES || byte_total < MIN_BYTES; phase++) begin
         if (phase != 0) begin
            // Change the count only with the encoder idle. The tail of the
            // last phase, if any, is a partial codeword, so the write abandons it.
            req_chan.valid <= 1'b0;
            burst_left = 0;
            wait_drained(SETTLE);
            case (phase)
               1:       setting = 6'd0;   // saturates up to one parity byte
               2:       setting = 6'd63;  // all bits set, saturates to the max
               3:       setting = 6'd33;  // just above the max
               default: setting = CFG_W'($urandom_range(0, 63));
            endcase
            write_parity_count(setting);
         end
         // First phase runs with no idling on either side; the rest mix.
         stall_mode <= (phase < 4) ? stall_mode_type'(phase)
                                   : stall_mode_type'($urandom_range(0, 3));
         gap_max = (phase == 0) ? 0 : $urandom_range(0, 8);

         // The first phase completes the codeword opened by the corner
         // bytes and may start another; later phases send a short partial
         // codeword that the next write, if any, drops.
         if (phase == 0) begin
            fill = CODEWORD_LENGTH_DEF - RESET_PARITY - 8;
            fill += $urandom_range(0, TAIL_MAX);
         end else begin
            fill = $urandom_range(1, TAIL_MAX);
         end
         repeat (fill) send_message_byte(pick_byte());
      end

      req_chan.valid <= 1'b0;
      wait_drained(DRAIN_CYCLES);
      if (mismatches == 0 && pending_beats == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
